[rtl/core/pzl1_pkg.sv]
// ----------------------------------------------------------------------------
// pzl1_pkg
// Shared types and constants for the packed zone L1 distance block.
// ----------------------------------------------------------------------------
package pzl1_pkg;

    localparam int BYTE_W     = 8;
    localparam int LANES      = 8;    // at most 8 zones fit in one byte step
    localparam int CARRY_W    = 7;
    localparam int BUF_W      = CARRY_W + BYTE_W;
    localparam int STEP_SUM_W = 11;   // 8 lanes x 255
    localparam int DIST_W     = 18;
    localparam int ZB_W       = 4;
    localparam int DIMS_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_MAX_DIMS = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 2'd1;

    localparam logic [ZB_W-1:0]   ZB_RESET   = 4'd2;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 11'd128;

    // Config block to datapath
    typedef struct packed {
        logic [ZB_W-1:0] zone_bits;   // clamped to 1..8
        logic            clear;       // register write: drop code in progress
    } t_cfg_ctl;

    // Result of unpacking one byte step
    typedef struct packed {
        logic [STEP_SUM_W-1:0] sum;
        logic [3:0]            zones;
        logic [2:0]            carry_cnt;
        logic [CARRY_W-1:0]    carry_a;
        logic [CARRY_W-1:0]    carry_b;
    } t_step;

endpackage

[rtl/core/packed_zone_l1_distance.sv]
// ----------------------------------------------------------------------------
// packed_zone_l1_distance
// L1 distance between two packed zone codes streamed one byte pair a transfer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_stall  | i_byte_a, i_byte_b
//  output  | out       | o_out_valid / i_out_stall| o_distance
//  config  | in        | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  One byte pair per cycle sustained while the output is not stalled.
//  A transfer lands in the input register and is unpacked and summed from
//  there once the output register is free or draining; the distance of a
//  code is loaded into the output register, which raises o_out_valid,
//  when the last byte pair of that code is stepped.
//  The carry / count / running-sum loop closes through the combinational
//  unpack lanes back into the code state registers.
//  Reset is synchronous, active low; it restores zone_bits=2, dims=128.
//  A stalled output holds the input register, which then stalls the input.
// ----------------------------------------------------------------------------
module packed_zone_l1_distance import pzl1_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input bytes
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_byte_a,
    input  logic [BYTE_W-1:0]     i_byte_b,
    // result
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DIST_W-1:0]     o_distance
);

    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam logic [DIST_W:0] SUM_MAX = {1'b0, {DIST_W{1'b1}}};

    t_cfg_ctl      cfg_ctl;
    logic [DW-1:0] dims_eff;

    pzl1_cfg #(
        .MAX_DIMS (MAX_DIMS),
        .DW       (DW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (cfg_ctl),
        .o_dims     (dims_eff)
    );

    // Input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_byte_a;
    logic [BYTE_W-1:0] r_byte_b;

    // Code state
    logic [CARRY_W-1:0] r_carry_a;
    logic [CARRY_W-1:0] r_carry_b;
    logic [2:0]         r_carry_cnt;
    logic [DW-1:0]      r_zones_done;
    logic [DIST_W-1:0]  r_sum;

    // Output register
    logic              r_out_valid;
    logic [DIST_W-1:0] r_distance;

    logic              advance;
    logic              accept;
    logic [BUF_W-1:0]  buf_a;
    logic [BUF_W-1:0]  buf_b;
    logic [3:0]        avail;
    logic [DW-1:0]     remaining;
    t_step             step;
    logic              done;
    logic [DIST_W:0]   sum_wide;
    logic [DIST_W-1:0] n_sum;

    // step the held byte pair when the output slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // merge leftover bits below the new byte
    assign buf_a     = BUF_W'(r_carry_a) | (BUF_W'(r_byte_a) << r_carry_cnt);
    assign buf_b     = BUF_W'(r_carry_b) | (BUF_W'(r_byte_b) << r_carry_cnt);
    assign avail     = 4'(r_carry_cnt) + 4'd8;
    assign remaining = dims_eff - r_zones_done;

    pzl1_unpack #(
        .MAX_DIMS (MAX_DIMS),
        .DW       (DW)
    ) u_unpack (
        .i_buf_a     (buf_a),
        .i_buf_b     (buf_b),
        .i_avail     (avail),
        .i_zone_bits (cfg_ctl.zone_bits),
        .i_remaining (remaining),
        .o_step      (step)
    );

    // saturate the running sum (only reachable for large MAX_DIMS)
    assign sum_wide = (DIST_W + 1)'(r_sum) + (DIST_W + 1)'(step.sum);
    assign n_sum    = (sum_wide > SUM_MAX) ? SUM_MAX[DIST_W-1:0]
                                           : sum_wide[DIST_W-1:0];
    assign done     = (32'(r_zones_done) + 32'(step.zones)) >= 32'(dims_eff);

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte_a <= i_byte_a;
            r_byte_b <= i_byte_b;
        end
    end

    // code state: cleared on reset, on config writes and at end of each code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_ctl.clear) begin
            r_carry_a    <= '0;
            r_carry_b    <= '0;
            r_carry_cnt  <= '0;
            r_zones_done <= '0;
            r_sum        <= '0;
        end else if (advance) begin
            if (done) begin
                r_carry_a    <= '0;
                r_carry_b    <= '0;
                r_carry_cnt  <= '0;
                r_zones_done <= '0;
                r_sum        <= '0;
            end else begin
                r_carry_a    <= step.carry_a;
                r_carry_b    <= step.carry_b;
                r_carry_cnt  <= step.carry_cnt;
                r_zones_done <= DW'(32'(r_zones_done) + 32'(step.zones));
                r_sum        <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && done) begin
            r_distance <= n_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;

endmodule

[rtl/core/pzl1_cfg.sv]
// ----------------------------------------------------------------------------
// pzl1_cfg
// Configuration registers with clamping of zone width and zone count.
// ----------------------------------------------------------------------------
module pzl1_cfg import pzl1_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DW       = $clog2(MAX_DIMS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg_ctl              o_ctl,
    output logic [DW-1:0]         o_dims
);

    logic [ZB_W-1:0]   r_zone_bits;
    logic [DIMS_W-1:0] r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_bits <= ZB_RESET;
            r_dims      <= DIMS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZONE_BITS: r_zone_bits <= i_cfg_data[ZB_W-1:0];
                CFG_DIMS:      r_dims      <= i_cfg_data[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_ctl.clear = i_cfg_we;
        if (r_zone_bits == '0) begin
            o_ctl.zone_bits = 4'd1;
        end else if (r_zone_bits > 4'd8) begin
            o_ctl.zone_bits = 4'd8;
        end else begin
            o_ctl.zone_bits = r_zone_bits;
        end

        if (r_dims == '0) begin
            o_dims = DW'(1);
        end else if (32'(r_dims) > 32'(MAX_DIMS)) begin
            o_dims = DW'(MAX_DIMS);
        end else begin
            o_dims = DW'(r_dims);
        end
    end

endmodule

[rtl/core/pzl1_unpack.sv]
// ----------------------------------------------------------------------------
// pzl1_unpack
// Splits one step's bit buffers into zone lanes, sums the absolute
// differences and works out the bits left over for the next byte.
// ----------------------------------------------------------------------------
module pzl1_unpack import pzl1_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DW       = $clog2(MAX_DIMS + 1)
) (
    input  logic [BUF_W-1:0] i_buf_a,
    input  logic [BUF_W-1:0] i_buf_b,
    input  logic [3:0]       i_avail,     // valid bits in the buffers, 8..15
    input  logic [ZB_W-1:0]  i_zone_bits,
    input  logic [DW-1:0]    i_remaining, // zones still owed in this code
    output t_step            o_step
);

    logic [7:0]            mask;
    logic [LANES-1:0]      lane_en;
    logic [BYTE_W-1:0]     za     [LANES];
    logic [BYTE_W-1:0]     zbv    [LANES];
    logic [BYTE_W-1:0]     diff   [LANES];
    logic [6:0]            consumed;
    logic [3:0]            left;
    logic [BUF_W-1:0]      rest_a;
    logic [BUF_W-1:0]      rest_b;
    logic [STEP_SUM_W-1:0] acc;

    assign mask = 8'((9'd1 << i_zone_bits) - 9'd1);

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            za[j]   = 8'(i_buf_a >> (6'(j) * 6'(i_zone_bits))) & mask;
            zbv[j]  = 8'(i_buf_b >> (6'(j) * 6'(i_zone_bits))) & mask;
            diff[j] = (za[j] >= zbv[j]) ? (za[j] - zbv[j]) : (zbv[j] - za[j]);
            // lane fits in the buffer and the code still needs it
            lane_en[j] = ((7'(j + 1) * 7'(i_zone_bits)) <= 7'(i_avail))
                         && (32'(i_remaining) > 32'(j));
        end
    end

    always_comb begin
        acc = '0;
        for (int j = 0; j < LANES; j++) begin
            if (lane_en[j]) begin
                acc = acc + STEP_SUM_W'(diff[j]);
            end
        end
    end

    assign o_step.zones = 4'($countones(lane_en));
    assign consumed     = 7'(o_step.zones) * 7'(i_zone_bits);
    assign left         = i_avail - consumed[3:0];
    assign rest_a       = i_buf_a >> consumed;
    assign rest_b       = i_buf_b >> consumed;

    assign o_step.sum       = acc;
    assign o_step.carry_cnt = left[2:0];
    assign o_step.carry_a   = rest_a[CARRY_W-1:0];
    assign o_step.carry_b   = rest_b[CARRY_W-1:0];

endmodule
